// ===== src/pxc_pkg.sv =====
// ----------------------------------------------------------------------------
// pxc_pkg
// Shared types and constants for the pixel compositor: op codes, register
// indexes, port widths and the stage records of the blend pipeline.
// ----------------------------------------------------------------------------
package pxc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ORDER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ORDER  = 3'd5;

    localparam logic [8:0]  TINT_RESET = 9'd256;
    localparam logic [11:0] GAIN_RESET = 12'd256;

    // floor(x / 255) estimate: (x * RECIP_255) >> 24, low by at most one
    localparam logic [16:0] RECIP_255 = 17'd65793;

    typedef enum logic [1:0] {
        OP_BLEND = 2'd0,
        OP_BLIT  = 2'd1,
        OP_COPY  = 2'd2,
        OP_FILL  = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             skip;
        logic [3:0][7:0]  ms;
        logic [3:0][7:0]  d;
        logic [2:0][8:0]  tm;
        logic [19:0]      p;
    } t_s1;

    typedef struct packed {
        t_op              op;
        logic             skip;
        logic [3:0][7:0]  ms;
        logic [3:0][7:0]  d;
        logic [2:0][16:0] st;
        logic [2:0][16:0] tf;
        logic [19:0]      p;
        logic [11:0]      q;
    } t_s2;

    typedef struct packed {
        t_op              op;
        logic             skip;
        logic [3:0][7:0]  ms;
        logic [3:0][7:0]  d;
        logic [2:0][16:0] st;
        logic [2:0][16:0] tf;
        logic [11:0]      sa;
    } t_s3;

    typedef struct packed {
        t_op              op;
        logic             skip;
        logic [3:0][7:0]  ms;
        logic [3:0][7:0]  d;
        logic [3:0][16:0] f1;
        logic [11:0]      f2;
        logic [12:0]      w;
        logic [3:0]       wide;
    } t_s4;

    typedef struct packed {
        t_op              op;
        logic             skip;
        logic [3:0][7:0]  ms;
        logic [3:0][7:0]  d;
        logic [3:0][28:0] a;
        logic [3:0][20:0] b;
        logic [3:0]       wide;
    } t_s5;

    typedef struct packed {
        logic [3:0][7:0]  px;
        logic             written;
    } t_res;

endpackage

// ===== src/pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// pixel_compositor
// Premultiplied source-over compositor with tint, global alpha, copy and
// solid fill, one pixel per clock through a six-stage pipeline.
// ----------------------------------------------------------------------------
// usage
//   a pixel transfer happens at a rising edge with start high and busy low;
//   busy stays low, so a new pixel may be given on every clock
//   each pixel yields one result on o_out_byte0..3 and o_written, marked by
//   o_done for exactly one cycle; the receiver takes it at the edge that
//   ends that cycle and cannot hold it off
//   the result passes through the stage registers r_s1 to r_s5 into r_res;
//   throughput is one pixel per cycle, set by the fully pipelined
//   multipliers and the divide-by-255 stages
//   registers are written through i_cfg_valid / o_cfg_ready (always ready),
//   by the user only while no pixel is in flight (not enforced by the block);
//   unknown indexes are ignored; a synchronous reset empties the pipeline and
//   restores tint 1.0, gain 1.0 and red-in-byte-0 order on both sides
// ----------------------------------------------------------------------------
module pixel_compositor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_op,
    input  logic [7:0]                     i_src_byte0,
    input  logic [7:0]                     i_src_byte1,
    input  logic [7:0]                     i_src_byte2,
    input  logic [7:0]                     i_src_byte3,
    input  logic [7:0]                     i_dst_byte0,
    input  logic [7:0]                     i_dst_byte1,
    input  logic [7:0]                     i_dst_byte2,
    input  logic [7:0]                     i_dst_byte3,
    output logic                           o_done,
    output logic [7:0]                     o_out_byte0,
    output logic [7:0]                     o_out_byte1,
    output logic [7:0]                     o_out_byte2,
    output logic [7:0]                     o_out_byte3,
    output logic                           o_written,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pxc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pxc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [8:0]  r_tint_red, r_tint_green, r_tint_blue;
    logic [11:0] r_alpha_gain;
    logic        r_source_order, r_dest_order;

    logic [5:0]     r_valid, n_valid;
    pxc_pkg::t_s1   r_s1, n_s1;
    pxc_pkg::t_s2   r_s2, n_s2;
    pxc_pkg::t_s3   r_s3, n_s3;
    pxc_pkg::t_s4   r_s4, n_s4;
    pxc_pkg::t_s5   r_s5, n_s5;
    pxc_pkg::t_res  r_res, n_res;

    logic        swap;
    logic [19:0] qx, rem;
    logic [8:0]  sac;
    logic signed [31:0] a_ext [4];
    logic signed [31:0] b_ext [4];
    logic signed [31:0] sum [4];
    logic [15:0]        shifted [4];
    logic [7:0]         blended [4];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint_red     <= pxc_pkg::TINT_RESET;
            r_tint_green   <= pxc_pkg::TINT_RESET;
            r_tint_blue    <= pxc_pkg::TINT_RESET;
            r_alpha_gain   <= pxc_pkg::GAIN_RESET;
            r_source_order <= 1'b0;
            r_dest_order   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pxc_pkg::CFG_TINT_RED:     r_tint_red     <= i_cfg_data[8:0];
                pxc_pkg::CFG_TINT_GREEN:   r_tint_green   <= i_cfg_data[8:0];
                pxc_pkg::CFG_TINT_BLUE:    r_tint_blue    <= i_cfg_data[8:0];
                pxc_pkg::CFG_ALPHA_GAIN:   r_alpha_gain   <= i_cfg_data[11:0];
                pxc_pkg::CFG_SOURCE_ORDER: r_source_order <= i_cfg_data[0];
                pxc_pkg::CFG_DEST_ORDER:   r_dest_order   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign n_valid = {r_valid[4:0], start & ~busy};

    // stage 1: byte mapping, tint placement, alpha product
    always_comb begin
        swap      = r_source_order != r_dest_order;
        n_s1.op   = pxc_pkg::t_op'(i_op);
        n_s1.ms[0] = swap ? i_src_byte2 : i_src_byte0;
        n_s1.ms[1] = i_src_byte1;
        n_s1.ms[2] = swap ? i_src_byte0 : i_src_byte2;
        n_s1.ms[3] = i_src_byte3;
        n_s1.d[0] = i_dst_byte0;
        n_s1.d[1] = i_dst_byte1;
        n_s1.d[2] = i_dst_byte2;
        n_s1.d[3] = i_dst_byte3;
        n_s1.tm[0] = r_dest_order ? r_tint_blue : r_tint_red;
        n_s1.tm[1] = r_tint_green;
        n_s1.tm[2] = r_dest_order ? r_tint_red : r_tint_blue;
        n_s1.p    = 20'(i_src_byte3) * 20'(r_alpha_gain);
        case (pxc_pkg::t_op'(i_op))
            pxc_pkg::OP_BLEND,
            pxc_pkg::OP_BLIT: n_s1.skip = (i_src_byte3 == 8'd0) || (r_alpha_gain == 12'd0);
            pxc_pkg::OP_FILL: n_s1.skip = r_alpha_gain == 12'd0;
            default:          n_s1.skip = 1'b0;
        endcase
    end

    // stage 2: reciprocal estimate of p / 255, tint products
    always_comb begin
        n_s2.op   = r_s1.op;
        n_s2.skip = r_s1.skip;
        n_s2.ms   = r_s1.ms;
        n_s2.d    = r_s1.d;
        n_s2.p    = r_s1.p;
        n_s2.q    = 12'((37'(r_s1.p) * 37'(pxc_pkg::RECIP_255)) >> 24);
        for (int m = 0; m < 3; m++) begin
            n_s2.st[m] = 17'(r_s1.ms[m]) * 17'(r_s1.tm[m]);
            n_s2.tf[m] = 17'({r_s1.tm[m], 8'd0}) - 17'(r_s1.tm[m]);
        end
    end

    // stage 3: quotient correction
    always_comb begin
        qx        = 20'({r_s2.q, 8'd0}) - 20'(r_s2.q);
        rem       = r_s2.p - qx;
        n_s3.op   = r_s2.op;
        n_s3.skip = r_s2.skip;
        n_s3.ms   = r_s2.ms;
        n_s3.d    = r_s2.d;
        n_s3.st   = r_s2.st;
        n_s3.tf   = r_s2.tf;
        n_s3.sa   = r_s2.q + 12'(rem >= 20'd255);
    end

    // stage 4: operand and weight selection per op
    always_comb begin
        sac       = (r_s3.sa > 12'd256) ? 9'd256 : r_s3.sa[8:0];
        n_s4.op   = r_s3.op;
        n_s4.skip = r_s3.skip;
        n_s4.ms   = r_s3.ms;
        n_s4.d    = r_s3.d;
        case (r_s3.op)
            pxc_pkg::OP_BLEND: begin
                n_s4.f2   = {3'd0, sac};
                n_s4.w    = 13'd256 - {4'd0, sac};
                n_s4.f1   = {17'd255, r_s3.st[2], r_s3.st[1], r_s3.st[0]};
                n_s4.wide = 4'b0111;
            end
            pxc_pkg::OP_FILL: begin
                n_s4.f2   = r_alpha_gain;
                n_s4.w    = 13'd256 - {1'b0, r_alpha_gain};
                n_s4.f1   = {17'd255, r_s3.tf[2], r_s3.tf[1], r_s3.tf[0]};
                n_s4.wide = 4'b0111;
            end
            default: begin
                n_s4.f2   = r_alpha_gain;
                n_s4.w    = 13'd256 - {1'b0, r_s3.sa};
                n_s4.f1   = {{9'd0, r_s3.ms[3]}, {9'd0, r_s3.ms[2]},
                             {9'd0, r_s3.ms[1]}, {9'd0, r_s3.ms[0]}};
                n_s4.wide = 4'b0000;
            end
        endcase
    end

    // stage 5: source and destination products
    always_comb begin
        n_s5.op   = r_s4.op;
        n_s5.skip = r_s4.skip;
        n_s5.ms   = r_s4.ms;
        n_s5.d    = r_s4.d;
        n_s5.wide = r_s4.wide;
        for (int m = 0; m < 4; m++) begin
            n_s5.a[m] = 29'(r_s4.f1[m]) * 29'(r_s4.f2);
            n_s5.b[m] = 21'($signed({1'b0, r_s4.d[m]}) * $signed(r_s4.w));
        end
    end

    // stage 6: sum, shift, saturate, select
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            a_ext[m] = $signed({3'd0, r_s5.a[m]});
            b_ext[m] = $signed({{11{r_s5.b[m][20]}}, r_s5.b[m]});
            sum[m]   = a_ext[m] + (r_s5.wide[m] ? (b_ext[m] <<< 8) : b_ext[m]);
            shifted[m] = r_s5.wide[m] ? 16'(sum[m] >>> 16) : 16'(sum[m] >>> 8);
            if (sum[m][31]) begin
                blended[m] = 8'd0;
            end else if (shifted[m] > 16'd255) begin
                blended[m] = 8'd255;
            end else begin
                blended[m] = shifted[m][7:0];
            end
        end
        if (r_s5.op == pxc_pkg::OP_COPY) begin
            n_res.px      = r_s5.ms;
            n_res.written = 1'b1;
        end else if (r_s5.skip) begin
            n_res.px      = r_s5.d;
            n_res.written = 1'b0;
        end else begin
            n_res.px      = {blended[3], blended[2], blended[1], blended[0]};
            n_res.written = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
        r_s4  <= n_s4;
        r_s5  <= n_s5;
        r_res <= n_res;
    end

    assign o_done      = r_valid[5];
    assign o_out_byte0 = r_res.px[0];
    assign o_out_byte1 = r_res.px[1];
    assign o_out_byte2 = r_res.px[2];
    assign o_out_byte3 = r_res.px[3];
    assign o_written   = r_res.written;

endmodule

// ===== verif/tb_pixel_compositor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_compositor
// Self-checking bench for the pixel compositor. Pixels go in through the
// start/busy port with random gaps; every result is checked against an
// in-bench model of the blend, blit, copy and fill arithmetic. Registers are
// rewritten between phases, with extreme gains, tints and both byte orders.
// ----------------------------------------------------------------------------
module tb_pixel_compositor;
    import pxc_pkg::*;

    localparam int PIPE_LAT = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_op;
    logic [7:0]            i_src_byte0;
    logic [7:0]            i_src_byte1;
    logic [7:0]            i_src_byte2;
    logic [7:0]            i_src_byte3;
    logic [7:0]            i_dst_byte0;
    logic [7:0]            i_dst_byte1;
    logic [7:0]            i_dst_byte2;
    logic [7:0]            i_dst_byte3;
    logic                  o_done;
    logic [7:0]            o_out_byte0;
    logic [7:0]            o_out_byte1;
    logic [7:0]            o_out_byte2;
    logic [7:0]            o_out_byte3;
    logic                  o_written;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // model copy of the registers
    longint tint_r;
    longint tint_g;
    longint tint_b;
    longint gain;
    bit     src_ord;
    bit     dst_ord;

    t_res   pending_px[$];
    int     n_errors;
    int     n_pixels;
    int     n_skipped;
    int     n_cfg_writes;
    int     n_per_op[4];

    pixel_compositor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_src_byte0 (i_src_byte0),
        .i_src_byte1 (i_src_byte1),
        .i_src_byte2 (i_src_byte2),
        .i_src_byte3 (i_src_byte3),
        .i_dst_byte0 (i_dst_byte0),
        .i_dst_byte1 (i_dst_byte1),
        .i_dst_byte2 (i_dst_byte2),
        .i_dst_byte3 (i_dst_byte3),
        .o_done      (o_done),
        .o_out_byte0 (o_out_byte0),
        .o_out_byte1 (o_out_byte1),
        .o_out_byte2 (o_out_byte2),
        .o_out_byte3 (o_out_byte3),
        .o_written   (o_written),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] sat_shift(longint v, int sh);
        if (v < 0)
            return 8'd0;
        v = v >>> sh;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_res composite_pixel(t_op op, logic [3:0][7:0] s,
                                             logic [3:0][7:0] d);
        t_res   r;
        longint sv[4];
        longint dv[4];
        longint sa;
        longint inv;
        int     sred;
        int     sblue;
        int     dred;
        int     dblue;
        int     m;
        bit     swap;
        sred  = src_ord ? 2 : 0;
        sblue = 2 - sred;
        dred  = dst_ord ? 2 : 0;
        dblue = 2 - dred;
        swap  = src_ord != dst_ord;
        for (int c = 0; c < 4; c++) begin
            sv[c] = s[c];
            dv[c] = d[c];
        end
        r.px      = d;
        r.written = 1'b1;
        case (op)
            OP_BLEND: begin
                if (sv[3] == 0 || gain == 0) begin
                    r.written = 1'b0;
                end else begin
                    sa = (sv[3] * gain) / 255;
                    if (sa > 256)
                        sa = 256;
                    inv = 256 - sa;
                    r.px[dred]  = sat_shift(sv[sred] * tint_r * sa + dv[dred] * inv * 256, 16);
                    r.px[1]     = sat_shift(sv[1] * tint_g * sa + dv[1] * inv * 256, 16);
                    r.px[dblue] = sat_shift(sv[sblue] * tint_b * sa + dv[dblue] * inv * 256, 16);
                    r.px[3]     = sat_shift(255 * sa + dv[3] * inv, 8);
                end
            end
            OP_BLIT: begin
                if (sv[3] == 0 || gain == 0) begin
                    r.written = 1'b0;
                end else begin
                    inv = 256 - (sv[3] * gain) / 255;
                    for (int c = 0; c < 4; c++) begin
                        m = (swap && (c == 0 || c == 2)) ? 2 - c : c;
                        r.px[m] = sat_shift(sv[c] * gain + dv[m] * inv, 8);
                    end
                end
            end
            OP_COPY: begin
                for (int c = 0; c < 4; c++) begin
                    m = (swap && (c == 0 || c == 2)) ? 2 - c : c;
                    r.px[m] = s[c];
                end
            end
            default: begin
                if (gain == 0) begin
                    r.written = 1'b0;
                end else begin
                    inv = 256 - gain;
                    r.px[dred]  = sat_shift(tint_r * gain * 255 + dv[dred] * inv * 256, 16);
                    r.px[1]     = sat_shift(tint_g * gain * 255 + dv[1] * inv * 256, 16);
                    r.px[dblue] = sat_shift(tint_b * gain * 255 + dv[dblue] * inv * 256, 16);
                    r.px[3]     = sat_shift(255 * gain + dv[3] * inv, 8);
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_pixel(input t_op op, input logic [3:0][7:0] s,
                              input logic [3:0][7:0] d);
        t_res want;
        start       <= 1'b1;
        i_op        <= op;
        i_src_byte0 <= s[0];
        i_src_byte1 <= s[1];
        i_src_byte2 <= s[2];
        i_src_byte3 <= s[3];
        i_dst_byte0 <= d[0];
        i_dst_byte1 <= d[1];
        i_dst_byte2 <= d[2];
        i_dst_byte3 <= d[3];
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        want = composite_pixel(op, s, d);
        pending_px.push_back(want);
        n_pixels++;
        n_per_op[op]++;
        if (!want.written)
            n_skipped++;
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_empty();
        start <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cfg_writes++;
        case (idx)
            CFG_TINT_RED:     tint_r  = data[8:0];
            CFG_TINT_GREEN:   tint_g  = data[8:0];
            CFG_TINT_BLUE:    tint_b  = data[8:0];
            CFG_ALPHA_GAIN:   gain    = data;
            CFG_SOURCE_ORDER: src_ord = data[0];
            CFG_DEST_ORDER:   dst_ord = data[0];
            default: ;
        endcase
    endtask

    function automatic int pick_gap(bit quiet);
        if (quiet)
            return 0;
        case ($urandom_range(0, 19))
            18:      return $urandom_range(4, 10);
            19:      return $urandom_range(11, 40);
            12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_alpha();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [11:0] rand_tint();
        case ($urandom_range(0, 5))
            0:       return 12'd0;
            1:       return 12'd256;
            2:       return 12'd255;
            3:       return 12'($urandom_range(0, 4095));
            default: return 12'($urandom_range(0, 256));
        endcase
    endfunction

    function automatic logic [11:0] rand_gain();
        case ($urandom_range(0, 11))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'd255;
            3:       return 12'd256;
            4:       return 12'd4095;
            5:       return 12'($urandom_range(0, 4095));
            default: return 12'($urandom_range(0, 600));
        endcase
    endfunction

    always @(posedge i_clk) begin : check_result
        t_res want;
        if (i_rst_n && o_done) begin
            if (pending_px.size() == 0) begin
                $error("result with nothing outstanding");
                n_errors++;
            end else begin
                want = pending_px.pop_front();
                if (o_out_byte0 !== want.px[0]) begin
                    $error("out_byte0: expected %0d, got %0d", want.px[0], o_out_byte0);
                    n_errors++;
                end
                if (o_out_byte1 !== want.px[1]) begin
                    $error("out_byte1: expected %0d, got %0d", want.px[1], o_out_byte1);
                    n_errors++;
                end
                if (o_out_byte2 !== want.px[2]) begin
                    $error("out_byte2: expected %0d, got %0d", want.px[2], o_out_byte2);
                    n_errors++;
                end
                if (o_out_byte3 !== want.px[3]) begin
                    $error("out_byte3: expected %0d, got %0d", want.px[3], o_out_byte3);
                    n_errors++;
                end
                if (o_written !== want.written) begin
                    $error("written: expected %0d, got %0d", want.written, o_written);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_default_extremes();
        send_pixel(OP_BLEND, 32'hFF_FF_FF_FF, 32'h00_00_00_00);
        send_pixel(OP_BLEND, 32'h00_FF_FF_FF, 32'h12_34_56_78);
        send_pixel(OP_BLEND, 32'h80_FF_00_FF, 32'hFF_00_FF_00);
        send_pixel(OP_BLIT,  32'hFF_FF_FF_FF, 32'h00_00_00_00);
        idle(3);
        send_pixel(OP_BLIT,  32'h01_10_20_30, 32'hFF_FF_FF_FF);
        send_pixel(OP_BLIT,  32'h00_FF_FF_FF, 32'hA5_5A_A5_5A);
        send_pixel(OP_COPY,  32'h00_12_34_56, 32'hFF_FF_FF_FF);
        send_pixel(OP_FILL,  32'h00_00_00_00, 32'h00_00_00_00);
        send_pixel(OP_FILL,  32'hFF_FF_FF_FF, 32'hFF_FF_FF_FF);
        wait_empty();
    endtask

    task automatic test_gain_extremes();
        write_reg(CFG_ALPHA_GAIN, 12'd0);
        send_pixel(OP_BLEND, 32'hFF_80_80_80, 32'h11_22_33_44);
        send_pixel(OP_BLIT,  32'hFF_80_80_80, 32'h11_22_33_44);
        send_pixel(OP_FILL,  32'hFF_80_80_80, 32'h11_22_33_44);
        send_pixel(OP_COPY,  32'hFF_80_80_80, 32'h11_22_33_44);
        wait_empty();
        write_reg(CFG_ALPHA_GAIN, 12'd4095);
        send_pixel(OP_BLIT,  32'h80_80_80_80, 32'hFF_00_FF_00);
        send_pixel(OP_FILL,  32'h00_00_00_00, 32'hFF_FF_FF_FF);
        send_pixel(OP_BLEND, 32'h02_40_80_C0, 32'h80_80_80_80);
        wait_empty();
        write_reg(CFG_ALPHA_GAIN, 12'd256);
        write_reg(CFG_TINT_RED, 12'd0);
        write_reg(CFG_TINT_GREEN, 12'd511);
        write_reg(CFG_TINT_BLUE, 12'hFFF);
        send_pixel(OP_BLEND, 32'hFF_FF_FF_FF, 32'h40_40_40_40);
        send_pixel(OP_FILL,  32'h00_00_00_00, 32'h40_40_40_40);
        wait_empty();
    endtask

    task automatic test_byte_orders();
        write_reg(CFG_TINT_RED, 12'd256);
        write_reg(CFG_TINT_GREEN, 12'd128);
        write_reg(CFG_TINT_BLUE, 12'd64);
        for (int k = 1; k < 4; k++) begin
            write_reg(CFG_SOURCE_ORDER, 12'(k & 1));
            write_reg(CFG_DEST_ORDER, 12'((k >> 1) & 1));
            send_pixel(OP_COPY,  32'hC0_30_20_10, 32'h00_00_00_00);
            send_pixel(OP_BLEND, 32'hC0_30_20_10, 32'h0F_0E_0D_0C);
            if (k == 2)
                send_pixel(OP_FILL, 32'h00_00_00_00, 32'h0F_0E_0D_0C);
            wait_empty();
        end
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        logic [3:0][7:0] s;
        logic [3:0][7:0] d;
        bit              quiet;
        for (int p = 0; p < phases; p++) begin
            write_reg(CFG_TINT_RED, rand_tint());
            write_reg(CFG_TINT_GREEN, rand_tint());
            write_reg(CFG_TINT_BLUE, rand_tint());
            write_reg(CFG_ALPHA_GAIN, rand_gain());
            write_reg(CFG_SOURCE_ORDER, 12'($urandom_range(0, 4095)));
            write_reg(CFG_DEST_ORDER, 12'($urandom_range(0, 4095)));
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < per_phase; n++) begin
                s = {rand_alpha(), rand_byte(), rand_byte(), rand_byte()};
                d = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
                send_pixel(t_op'($urandom_range(0, 3)), s, d);
                idle(pick_gap(quiet));
            end
            wait_empty();
        end
    endtask

    task automatic test_pause_until_empty();
        logic [3:0][7:0] s;
        logic [3:0][7:0] d;
        for (int burst = 0; burst < 2; burst++) begin
            for (int n = 0; n < 20; n++) begin
                s = {rand_alpha(), rand_byte(), rand_byte(), rand_byte()};
                d = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
                send_pixel(t_op'($urandom_range(0, 3)), s, d);
            end
            // hold the sender off until the pipeline has emptied
            wait_empty();
        end
    endtask

    initial begin
        n_errors     = 0;
        n_pixels     = 0;
        n_skipped    = 0;
        n_cfg_writes = 0;
        n_per_op     = '{default: 0};
        tint_r       = TINT_RESET;
        tint_g       = TINT_RESET;
        tint_b       = TINT_RESET;
        gain         = GAIN_RESET;
        src_ord      = 1'b0;
        dst_ord      = 1'b0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_BLEND;
        i_src_byte0 <= '0;
        i_src_byte1 <= '0;
        i_src_byte2 <= '0;
        i_src_byte3 <= '0;
        i_dst_byte0 <= '0;
        i_dst_byte1 <= '0;
        i_dst_byte2 <= '0;
        i_dst_byte3 <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_extremes();
        test_gain_extremes();
        test_byte_orders();
        test_random_settings(8, 100);
        test_pause_until_empty();
        wait_empty();

        $display("%0d pixels, %0d skipped at zero alpha; blend %0d blit %0d copy %0d fill %0d",
                 n_pixels, n_skipped, n_per_op[OP_BLEND], n_per_op[OP_BLIT],
                 n_per_op[OP_COPY], n_per_op[OP_FILL]);
        $display("%0d register writes over tint, gain and byte order settings", n_cfg_writes);
        if (n_errors == 0 && pending_px.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
